// File: rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int FILL_W   = 5;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// One command beat.
	typedef struct packed {
		logic               action;
		logic signed [31:0] value_in;
		logic        [7:0]  prio_in;
	} item_t;

	// One result beat.
	typedef struct packed {
		status_t             status;
		logic signed [31:0]  value_out;
		logic        [7:0]   prio_out;
		logic [FILL_W-1:0]   fill_level;
	} result_t;

	// Contents of one queue slot.
	typedef struct packed {
		logic signed [31:0] value;
		logic        [7:0]  prio;
	} entry_t;

	// Shift control broadcast to every cell.
	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t new_entry;
	} cell_ctl_t;

endpackage

// File: rtl/spq_cell.sv
// One slot of the sorted shift chain: holds an entry, shifts right on insert, left on remove.
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  logic               occ,
	input  logic               left_after,
	input  spq_pkg::entry_t    left_entry,
	input  spq_pkg::entry_t    right_entry,
	output logic               after,
	output spq_pkg::entry_t    entry
);
	import spq_pkg::*;

	entry_t entry_q;

	// New entry belongs at or before this slot when it is empty or holds a larger number.
	assign after = !occ || (entry_q.prio > ctl.new_entry.prio);
	assign entry = entry_q;

	// Insert: slots past the insert point take the left neighbor; the insert point takes
	// the new entry. Remove: every slot takes its right neighbor.
	always_ff @(posedge clk) begin
		if (ctl.ins && after) begin
			entry_q <= left_after ? left_entry : ctl.new_entry;
		end else if (ctl.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule

// File: rtl/sorted_priority_queue.sv
// Sorted priority queue built as a chain of shift cells, lowest priority number first.
//
// Takes one command beat per clock: busy is never raised, so start may be held high
// every cycle. The result of each beat appears on result, marked by done, in the cycle
// after the beat is accepted, and lasts exactly one cycle. Each slot of the queue is a
// cell that compares its priority with the incoming one and shifts into place, which
// is what sets the one-beat-per-clock rate. Equal priorities leave in arrival
// order. An insert into a full queue reports full and a remove from an empty queue
// reports empty; neither changes the contents.
module sorted_priority_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  spq_pkg::item_t    item,
	output logic              done,
	output spq_pkg::result_t  result
);
	import spq_pkg::*;

	logic [CNT_W-1:0]  count_q;
	logic              done_q;
	result_t           result_q;
	cell_ctl_t         ctl;
	logic              accept;
	logic              full;
	logic              empty;
	logic [CAPACITY-1:0] occ;
	logic [CAPACITY-1:0] after;
	entry_t            entries [CAPACITY];

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign empty  = (count_q == '0);

	// Broadcast shift command.
	always_comb begin
		ctl.ins             = accept && (item.action == ACT_INSERT) && !full;
		ctl.rem             = accept && (item.action == ACT_REMOVE) && !empty;
		ctl.new_entry.value = item.value_in;
		ctl.new_entry.prio  = item.prio_in;
	end

	// Cell chain.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign occ[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			spq_cell u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.occ         (occ[i]),
				.left_after  (1'b0),
				.left_entry  (ctl.new_entry),
				.right_entry (entries[i+1]),
				.after       (after[i]),
				.entry       (entries[i])
			);
		end else if (i == CAPACITY - 1) begin : g_tail
			spq_cell u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.occ         (occ[i]),
				.left_after  (after[i-1]),
				.left_entry  (entries[i-1]),
				.right_entry (entries[i]),
				.after       (after[i]),
				.entry       (entries[i])
			);
		end else begin : g_mid
			spq_cell u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.occ         (occ[i]),
				.left_after  (after[i-1]),
				.left_entry  (entries[i-1]),
				.right_entry (entries[i+1]),
				.after       (after[i]),
				.entry       (entries[i])
			);
		end
	end

	// Fill count and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (ctl.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.rem) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.value_out <= '0;
			result_q.prio_out  <= '0;
			if (item.action == ACT_INSERT) begin
				if (full) begin
					result_q.status     <= ST_FULL;
					result_q.fill_level <= FILL_W'(count_q);
				end else begin
					result_q.status     <= ST_INSERTED;
					result_q.fill_level <= FILL_W'(count_q + CNT_W'(1));
				end
			end else begin
				if (empty) begin
					result_q.status     <= ST_EMPTY;
					result_q.fill_level <= FILL_W'(count_q);
				end else begin
					result_q.status     <= ST_REMOVED;
					result_q.value_out  <= entries[0].value;
					result_q.prio_out   <= entries[0].prio;
					result_q.fill_level <= FILL_W'(count_q - CNT_W'(1));
				end
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
